// ----- hdl/vector_rescale_to_length_macros.svh -----
// assertion macros shared by the rescale block
`ifndef VECTOR_RESCALE_TO_LENGTH_MACROS_SVH
`define VECTOR_RESCALE_TO_LENGTH_MACROS_SVH

// same-cycle implication
`define VRL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/vrl_pkg.sv -----
// ----------------------------------------------------------------------------
// vrl_pkg
// types, constants and step functions of the vector rescale pipeline
// ----------------------------------------------------------------------------
package vrl_pkg;

	localparam int W         = 32;
	localparam int LANES     = 3;
	localparam int SQ_STEPS  = 32;
	localparam int DIV_STEPS = 32;
	localparam int PROD_W    = 63;
	localparam int RAD_W     = 64;
	localparam int SQ_REM_W  = 34;

	localparam logic [W-1:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [W-1:0] NEG_MAG = 32'h8000_0000;

	typedef logic [LANES-1:0][PROD_W-1:0] prod_vec_t;
	typedef logic [LANES-1:0][W-1:0]      word_vec_t;

	// sideband carried alongside the square root
	typedef struct packed {
		logic [LANES-1:0] neg;
		logic             neg_t;
		prod_vec_t        prod;
	} sq_side_t;

	// sideband carried alongside the division
	typedef struct packed {
		logic [LANES-1:0] neg;
		logic             neg_t;
		logic             zero;
	} dv_side_t;

	typedef struct packed {
		logic [SQ_REM_W-1:0] rem;
		logic [W-1:0]        root;
	} sq_acc_t;

	typedef struct packed {
		logic [W-1:0] rem;
		logic         qbit;
	} dv_acc_t;

	// one digit of the square root, two radicand bits in
	function automatic sq_acc_t sqrt_step(input sq_acc_t acc, input logic [1:0] bits);
		logic [SQ_REM_W+1:0] r;
		logic [SQ_REM_W+1:0] t;
		sq_acc_t             res;
		r = {acc.rem, bits};
		t = {2'b00, acc.root, 2'b01};
		if (r >= t) begin
			r        = r - t;
			res.root = {acc.root[W-2:0], 1'b1};
		end else begin
			res.root = {acc.root[W-2:0], 1'b0};
		end
		res.rem = r[SQ_REM_W-1:0];
		return res;
	endfunction

	// one restoring division step
	function automatic dv_acc_t div_step(input logic [W-1:0] rem, input logic b,
		input logic [W-1:0] m);
		logic [W:0] r;
		dv_acc_t    res;
		r = {rem, b};
		if (r >= {1'b0, m}) begin
			r        = r - {1'b0, m};
			res.qbit = 1'b1;
		end else begin
			res.qbit = 1'b0;
		end
		res.rem = r[W-1:0];
		return res;
	endfunction

	// apply sign and saturate
	function automatic logic [W-1:0] sign_sat(input logic [W-1:0] q, input logic neg);
		logic [W-1:0] c;
		if (neg) begin
			c = (q > NEG_MAG) ? NEG_MAG : q;
			return ~c + 1'b1;
		end
		return (q > POS_MAX) ? POS_MAX : q;
	endfunction

endpackage

// ----- hdl/vrl_if.sv -----
// ----------------------------------------------------------------------------
// vrl_in_if / vrl_out_if
// valid/ready channels of the vector rescale block
// ----------------------------------------------------------------------------
interface vrl_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;
	logic signed [31:0] target_length;
	modport source (output valid, vec_x, vec_y, vec_z, target_length, input ready);
	modport sink (input valid, vec_x, vec_y, vec_z, target_length, output ready);
endinterface

interface vrl_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic               zero_vector;
	modport source (output valid, out_x, out_y, out_z, zero_vector, input ready);
	modport sink (input valid, out_x, out_y, out_z, zero_vector, output ready);
endinterface

// ----- hdl/vrl_sqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// vrl_sqrt_pipe
// pipelined integer square root, one result digit per stage
// ----------------------------------------------------------------------------
module vrl_sqrt_pipe (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [vrl_pkg::RAD_W-1:0]     rad,
	input  vrl_pkg::sq_side_t             side_in,
	output logic                          out_valid,
	output logic [vrl_pkg::W-1:0]         root,
	output vrl_pkg::sq_side_t             side_out
);
	import vrl_pkg::*;

	logic                vld_s  [0:SQ_STEPS];
	logic [RAD_W-1:0]    rad_s  [0:SQ_STEPS];
	sq_acc_t             acc_s  [0:SQ_STEPS];
	sq_side_t            side_s [0:SQ_STEPS];

	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = rad;
	assign acc_s[0]  = '0;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_stage
		sq_acc_t nxt;
		assign nxt = sqrt_step(acc_s[i], rad_s[i][RAD_W-1:RAD_W-2]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i+1]  <= {rad_s[i][RAD_W-3:0], 2'b00};
				acc_s[i+1]  <= nxt;
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = vld_s[SQ_STEPS];
	assign root      = acc_s[SQ_STEPS].root;
	assign side_out  = side_s[SQ_STEPS];

endmodule

// ----- hdl/vrl_div_pipe.sv -----
// ----------------------------------------------------------------------------
// vrl_div_pipe
// three-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module vrl_div_pipe (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [vrl_pkg::W-1:0]     divisor,
	input  vrl_pkg::prod_vec_t        dividend,
	input  vrl_pkg::dv_side_t         side_in,
	output logic                      out_valid,
	output vrl_pkg::word_vec_t        quot,
	output vrl_pkg::dv_side_t         side_out
);
	import vrl_pkg::*;

	logic        vld_s  [0:DIV_STEPS];
	logic [W-1:0] dvs_s [0:DIV_STEPS];
	word_vec_t   rem_s  [0:DIV_STEPS];
	word_vec_t   low_s  [0:DIV_STEPS];
	word_vec_t   quo_s  [0:DIV_STEPS];
	dv_side_t    side_s [0:DIV_STEPS];

	assign vld_s[0]  = in_valid;
	assign dvs_s[0]  = divisor;
	assign quo_s[0]  = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < LANES; k++) begin : g_load
		// upper part is below the divisor since the quotient fits 32 bits
		assign rem_s[0][k] = {1'b0, dividend[k][PROD_W-1:W]};
		assign low_s[0][k] = dividend[k][W-1:0];
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_stage
		dv_acc_t nxt [LANES];

		for (genvar k = 0; k < LANES; k++) begin : g_lane
			assign nxt[k] = div_step(rem_s[i][k], low_s[i][k][W-1], dvs_s[i]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvs_s[i+1]  <= dvs_s[i];
				side_s[i+1] <= side_s[i];
				for (int k = 0; k < LANES; k++) begin
					rem_s[i+1][k] <= nxt[k].rem;
					low_s[i+1][k] <= {low_s[i][k][W-2:0], 1'b0};
					quo_s[i+1][k] <= {quo_s[i][k][W-2:0], nxt[k].qbit};
				end
			end
		end
	end

	assign out_valid = vld_s[DIV_STEPS];
	assign quot      = quo_s[DIV_STEPS];
	assign side_out  = side_s[DIV_STEPS];

endmodule

// ----- hdl/vector_rescale_to_length.sv -----
// ----------------------------------------------------------------------------
// vector_rescale_to_length
// rescales a signed fixed point 3d vector to a requested length
// ----------------------------------------------------------------------------
// usage
//   vec_in carries one beat per vector: vec_x, vec_y, vec_z and target_length,
//   all signed q16.16. vec_out returns one beat per input beat, in order:
//   out_x, out_y, out_z (saturated q16.16) and zero_vector.
//   each component becomes component * target_length / |v|, where |v| is the
//   floor square root of the exact sum of squares, truncated toward zero
//   a zero vector gives zero outputs with zero_vector set
// throughput and pipeline
//   one beat per cycle unless vec_out stalls the pipe. absolute values,
//   multipliers and the sum of squares take three stages, the square root
//   32 stages (one root bit each), the divider 32 stages (one quotient bit
//   each) and sign/saturation one output register
// reset and stall
//   arst_n clears every valid bit; no other state is kept. the whole pipe
//   advances together: while the output beat waits on vec_out.ready the pipe
//   holds and vec_in.ready is low, so nothing is lost or repeated
// ----------------------------------------------------------------------------
`include "vector_rescale_to_length_macros.svh"

module vector_rescale_to_length (
	input  logic     clk,
	input  logic     arst_n,
	vrl_in_if.sink   vec_in,
	vrl_out_if.source vec_out
);
	import vrl_pkg::*;

	// global advance: output register empty or being drained
	logic out_valid_q;
	logic en;
	assign en           = !out_valid_q || vec_out.ready;
	assign vec_in.ready = en;

	// stage 1: magnitudes and signs
	logic             v_s1;
	word_vec_t        a_s1;
	logic [W-1:0]     t_s1;
	logic [LANES-1:0] neg_s1;
	logic             negt_s1;

	function automatic logic [W-1:0] mag32(input logic [W-1:0] v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= vec_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0] <= mag32(vec_in.vec_x);
			a_s1[1] <= mag32(vec_in.vec_y);
			a_s1[2] <= mag32(vec_in.vec_z);
			t_s1    <= mag32(vec_in.target_length);
			neg_s1  <= {vec_in.vec_z[W-1], vec_in.vec_y[W-1], vec_in.vec_x[W-1]};
			negt_s1 <= vec_in.target_length[W-1];
		end
	end

	// stage 2: squares and products with the target, one multiplier per lane each
	logic                                v_s2;
	logic [LANES-1:0][RAD_W-1:0]         sqr_s2;
	sq_side_t                            side_s2;
	logic [LANES-1:0][2*W-1:0]           sqr_c;
	logic [LANES-1:0][2*W-1:0]           prod_c;

	for (genvar k = 0; k < LANES; k++) begin : g_mul
		assign sqr_c[k]  = a_s1[k] * a_s1[k];
		assign prod_c[k] = a_s1[k] * t_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqr_s2        <= sqr_c;
			side_s2.neg   <= neg_s1;
			side_s2.neg_t <= negt_s1;
			for (int k = 0; k < LANES; k++) begin
				side_s2.prod[k] <= prod_c[k][PROD_W-1:0];
			end
		end
	end

	// stage 3: sum of squares, fits 64 bits since each square is at most 2^62
	logic             v_s3;
	logic [RAD_W-1:0] sum_s3;
	sq_side_t         side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= sqr_s2[0] + sqr_s2[1] + sqr_s2[2];
			side_s3 <= side_s2;
		end
	end

	// square root
	logic         sq_valid;
	logic [W-1:0] sq_root;
	sq_side_t     sq_side;

	vrl_sqrt_pipe u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s3),
		.rad      (sum_s3),
		.side_in  (side_s3),
		.out_valid(sq_valid),
		.root     (sq_root),
		.side_out (sq_side)
	);

	// division by the magnitude; a zero root is flagged and masked at the end
	dv_side_t  dv_side_in;
	logic      dv_valid;
	word_vec_t dv_quot;
	dv_side_t  dv_side;

	assign dv_side_in.neg   = sq_side.neg;
	assign dv_side_in.neg_t = sq_side.neg_t;
	assign dv_side_in.zero  = (sq_root == '0);

	vrl_div_pipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sq_valid),
		.divisor  (sq_root),
		.dividend (sq_side.prod),
		.side_in  (dv_side_in),
		.out_valid(dv_valid),
		.quot     (dv_quot),
		.side_out (dv_side)
	);

	// output register: sign, saturation and zero-vector masking
	word_vec_t out_q;
	logic      zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_q <= dv_side.zero;
			for (int k = 0; k < LANES; k++) begin
				out_q[k] <= dv_side.zero ? '0
					: sign_sat(dv_quot[k], dv_side.neg[k] ^ dv_side.neg_t);
			end
		end
	end

	assign vec_out.valid       = out_valid_q;
	assign vec_out.out_x       = out_q[0];
	assign vec_out.out_y       = out_q[1];
	assign vec_out.out_z       = out_q[2];
	assign vec_out.zero_vector = zero_q;

	// checks
	`VRL_ASSERT_NOW(a_ready_follows_drain, clk, arst_n, 1'b1, vec_in.ready == (!out_valid_q || vec_out.ready), "input ready does not follow output drain")
	`VRL_ASSERT_NOW(a_zero_masks, clk, arst_n, out_valid_q && zero_q, out_q[0] == '0 && out_q[1] == '0 && out_q[2] == '0, "zero vector with nonzero outputs")
	`VRL_ASSERT_NEXT(a_stall_holds_root, clk, arst_n, !en, $stable(sq_root) && $stable(sq_valid), "square root stage moved during a stall")

endmodule

// ----- dv/vector_rescale_to_length_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_rescale_to_length_checker
// watches both channels of the rescale block, predicts every result beat from
// the accepted input beats and compares them field by field, in order
// ----------------------------------------------------------------------------
module vector_rescale_to_length_checker (
	input  logic      clk,
	input  logic      arst_n,
	vrl_in_if.sink    vec_in,
	vrl_out_if.sink   vec_out,
	output int        fail_count,
	output int        pending
);

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        zero;
	} rescaled_t;

	rescaled_t rescaled_q[$];

	assign pending = rescaled_q.size();

	function automatic logic [63:0] floor_root(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] bit_w;
		rem   = v;
		root  = '0;
		bit_w = 64'd1 << 62;
		while (bit_w > rem)
			bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (rem >= root + bit_w) begin
				rem  = rem - (root + bit_w);
				root = (root >> 1) + bit_w;
			end else begin
				root = root >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return root;
	endfunction

	function automatic logic [31:0] scaled_lane(input logic [31:0] c, input logic [31:0] t,
		input logic [63:0] mag);
		logic [63:0] a;
		logic [63:0] at;
		logic [63:0] q;
		a  = c[31] ? 64'h1_0000_0000 - {32'd0, c} : {32'd0, c};
		at = t[31] ? 64'h1_0000_0000 - {32'd0, t} : {32'd0, t};
		q  = (a * at) / mag;
		if (c[31] != t[31]) begin
			if (q > 64'h8000_0000)
				q = 64'h8000_0000;
			return 32'(64'h1_0000_0000 - q);
		end
		if (q > 64'h7FFF_FFFF)
			q = 64'h7FFF_FFFF;
		return q[31:0];
	endfunction

	function automatic rescaled_t rescale(input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z, input logic [31:0] t);
		logic [63:0] ax;
		logic [63:0] ay;
		logic [63:0] az;
		logic [63:0] mag;
		rescaled_t   r;
		ax  = x[31] ? 64'h1_0000_0000 - {32'd0, x} : {32'd0, x};
		ay  = y[31] ? 64'h1_0000_0000 - {32'd0, y} : {32'd0, y};
		az  = z[31] ? 64'h1_0000_0000 - {32'd0, z} : {32'd0, z};
		mag = floor_root(ax * ax + ay * ay + az * az);
		if (mag == 0) begin
			r = '{x: '0, y: '0, z: '0, zero: 1'b1};
		end else begin
			r.x    = scaled_lane(x, t, mag);
			r.y    = scaled_lane(y, t, mag);
			r.z    = scaled_lane(z, t, mag);
			r.zero = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rescaled_t want;
		int        errs;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			errs = 0;
			if (vec_in.valid && vec_in.ready)
				rescaled_q.push_back(rescale(vec_in.vec_x, vec_in.vec_y, vec_in.vec_z,
					vec_in.target_length));
			if (vec_out.valid && vec_out.ready) begin
				if (rescaled_q.size() == 0) begin
					$error("result beat with nothing expected");
					errs = errs + 1;
				end else begin
					want = rescaled_q.pop_front();
					if (vec_out.out_x !== want.x) begin
						$error("out_x: expected %h, got %h", want.x, vec_out.out_x);
						errs = errs + 1;
					end
					if (vec_out.out_y !== want.y) begin
						$error("out_y: expected %h, got %h", want.y, vec_out.out_y);
						errs = errs + 1;
					end
					if (vec_out.out_z !== want.z) begin
						$error("out_z: expected %h, got %h", want.z, vec_out.out_z);
						errs = errs + 1;
					end
					if (vec_out.zero_vector !== want.zero) begin
						$error("zero_vector: expected %b, got %b", want.zero,
							vec_out.zero_vector);
						errs = errs + 1;
					end
				end
			end
			fail_count <= fail_count + errs;
		end
	end

endmodule

// ----- dv/tb_vector_rescale_to_length.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector_rescale_to_length
// drives directed and random vectors into the rescale block under random
// idling and long output stalls; the checker predicts and compares results
// ----------------------------------------------------------------------------
module tb_vector_rescale_to_length;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;

	// idle percentages of sender and receiver, changed by phase
	int   send_idle;
	int   recv_idle;
	// long receiver hold-off request, counted in the receiver process
	int   hold_cycles;

	vrl_in_if  vec_in ();
	vrl_out_if vec_out ();

	vector_rescale_to_length i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.vec_in  (vec_in.sink),
		.vec_out (vec_out.source)
	);

	vector_rescale_to_length_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.vec_in     (vec_in.sink),
		.vec_out    (vec_out.sink),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// generous limit: pipe is 68 deep
	initial begin
		#400000;
		$display("Some tests failed");
		$finish;
	end

	// receiver: random back-pressure plus an optional long hold-off
	initial begin
		vec_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				vec_out.ready <= 1'b0;
				hold_cycles    = hold_cycles - 1;
			end else begin
				vec_out.ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// one vector beat, with random gaps before it
	task automatic send_vector(input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z, input logic [31:0] t);
		while ($urandom_range(99) < send_idle) begin
			vec_in.valid <= 1'b0;
			@(posedge clk);
		end
		vec_in.valid         <= 1'b1;
		vec_in.vec_x         <= x;
		vec_in.vec_y         <= y;
		vec_in.vec_z         <= z;
		vec_in.target_length <= t;
		do
			@(posedge clk);
		while (!vec_in.ready);
	endtask

	// random component: full range, small, extreme, zero or within +/-2^19
	function automatic logic [31:0] pick_word();
		case ($urandom_range(5))
			0:       return 32'($signed($urandom_range(200)) - 100);
			1:       return ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			2:       return 32'h0;
			3:       return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
			default: return $urandom();
		endcase
	endfunction

	task automatic random_vectors(input int count);
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		for (int i = 0; i < count; i++) begin
			x = pick_word();
			y = pick_word();
			z = pick_word();
			// one-axis vectors hit the saturation case with a minimum target
			if ($urandom_range(9) == 0) begin
				y = '0;
				z = '0;
			end
			send_vector(x, y, z, pick_word());
		end
	endtask

	task automatic drain();
		vec_in.valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		vec_in.valid         = 1'b0;
		vec_in.vec_x         = '0;
		vec_in.vec_y         = '0;
		vec_in.vec_z         = '0;
		vec_in.target_length = '0;
		send_idle            = 22;
		recv_idle            = 53;
		hold_cycles          = 0;
		arst_n               = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero vector, zero target, extremes, positive saturation
		send_vector(32'h0, 32'h0, 32'h0, 32'h0001_0000);
		send_vector(32'h0, 32'h0, 32'h0, 32'h8000_0000);
		send_vector(32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 32'h0);
		send_vector(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h8000_0000);
		send_vector(32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000);
		send_vector(32'h0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
		send_vector(32'h0, 32'h0, 32'h0000_0001, 32'h8000_0000);
		send_vector(32'h0, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000);
		send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000);
		send_vector(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_0000);
		send_vector(32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0005_0000);
		send_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_vector(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0);

		random_vectors(140);

		// long receiver stall while the sender keeps offering
		hold_cycles = 200;
		random_vectors(20);

		// pause until every result is back
		drain();

		send_idle = 53;
		recv_idle = 22;
		random_vectors(140);

		send_idle = 0;
		recv_idle = 0;
		random_vectors(140);

		drain();
		repeat (80) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
